@@ hdl/keyed_fifo_with_cancel_macros.svh @@
// Assertion macros for the keyed queue top level.
// No dependencies; include by bare file name from modules that assert.
`ifndef KEYED_FIFO_WITH_CANCEL_MACROS_SVH
`define KEYED_FIFO_WITH_CANCEL_MACROS_SVH

// Same-cycle implication, checked out of reset
`define KFC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define KFC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kfc_pkg.sv @@
// Shared types and codes for the keyed queue with cancel.
// No dependencies; imported by the controller, datapath and top level.
package kfc_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_CHECK  = 2'd2,
        MODE_CLEAR  = 2'd3
    } kfc_mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } kfc_status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_COMPARE = 2'd1,
        ST_APPLY   = 2'd2,
        ST_REPORT  = 2'd3
    } kfc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic compare;
        logic apply;
        logic report;
    } kfc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic res_pending;
    } kfc_stat_t;

endpackage

@@ hdl/kfc_ctrl.sv @@
// Sequencing state machine for the keyed queue: load, compare, apply, report.
// Depends on kfc_pkg for state, command and status types.
module kfc_ctrl
    import kfc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      m_ready,
    input  kfc_stat_t stat,
    output kfc_cmd_t  cmd
);

    kfc_state_t state_reg;
    kfc_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                cmd.compare = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                // hold until the result register is free
                if (!stat.res_pending || m_ready) begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/kfc_datapath.sv @@
// Key store, match compare, compaction shift and result register.
// Depends on kfc_pkg; driven by commands from kfc_ctrl.
module kfc_datapath
    import kfc_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32,
    parameter int CNT_BITS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kfc_cmd_t            cmd,
    output kfc_stat_t           stat,
    input  kfc_mode_t           in_mode,
    input  logic [KEY_BITS-1:0] in_key,
    input  logic                m_ready,
    output logic                out_valid,
    output kfc_status_t         out_status,
    output logic                out_found,
    output logic [CNT_BITS-1:0] out_count,
    output logic                out_empty,
    output logic [KEY_BITS-1:0] out_front,
    output logic [KEY_BITS-1:0] out_rear
);

    localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SCAN_STEPS = $clog2(DEPTH);

    // Request registers
    kfc_mode_t           mode_reg;
    logic [KEY_BITS-1:0] key_reg;

    // Key store, front at index 0
    logic [KEY_BITS-1:0] entry_reg  [DEPTH];
    logic [KEY_BITS-1:0] entry_next [DEPTH];
    logic [KEY_BITS-1:0] upper      [DEPTH];
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    // Compare and outcome
    logic [DEPTH-1:0]    match_reg;
    logic [DEPTH-1:0]    match_next;
    logic [DEPTH-1:0]    shift_mask;
    logic                hit;
    logic                append_ok;
    kfc_status_t         status_reg;
    kfc_status_t         status_next;
    logic                found_reg;
    logic                found_next;

    // Result register
    logic                out_valid_reg;
    kfc_status_t         out_status_reg;
    logic                out_found_reg;
    logic [CNT_BITS-1:0] out_count_reg;
    logic                out_empty_reg;
    logic [KEY_BITS-1:0] out_front_reg;
    logic [KEY_BITS-1:0] out_rear_reg;
    logic [CNT_BITS-1:0] rear_pos;
    logic [IDX_BITS-1:0] rear_idx;

    assign hit       = |match_reg;
    assign append_ok = (count_reg != CNT_BITS'(DEPTH));

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            key_reg  <= in_key;
        end
    end

    // Compare every valid entry against the key
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match_next[i] = (CNT_BITS'(i) < count_reg) && (entry_reg[i] == key_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            match_reg <= match_next;
        end
    end

    // Mark the first match and everything behind it for the shift
    always_comb begin
        shift_mask = match_reg;
        for (int s = 0; s < SCAN_STEPS; s++) begin
            shift_mask = shift_mask | (shift_mask << (1 << s));
        end
    end

    // Neighbor taps for compaction
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_tap
            if (g == DEPTH - 1) begin : g_last
                assign upper[g] = entry_reg[g];
            end else begin : g_mid
                assign upper[g] = entry_reg[g + 1];
            end
        end
    endgenerate

    // Next store contents: append at the rear or close the gap
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
            if (mode_reg == MODE_APPEND && append_ok && count_reg == CNT_BITS'(i)) begin
                entry_next[i] = key_reg;
            end else if (mode_reg == MODE_CANCEL && shift_mask[i]) begin
                entry_next[i] = upper[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            entry_reg <= entry_next;
        end
    end

    // Occupancy and outcome of the operation
    always_comb begin
        count_next  = count_reg;
        status_next = STAT_DONE;
        found_next  = 1'b0;
        case (mode_reg)
            MODE_APPEND: begin
                if (append_ok) begin
                    count_next = count_reg + CNT_BITS'(1);
                end else begin
                    status_next = STAT_FULL;
                end
            end
            MODE_CANCEL: begin
                if (hit) begin
                    count_next = count_reg - CNT_BITS'(1);
                    found_next = 1'b1;
                end else begin
                    status_next = STAT_MISS;
                end
            end
            MODE_CHECK: begin
                found_next = hit;
            end
            MODE_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.apply) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    // Rear entry sits just below the count
    assign rear_pos = count_reg - CNT_BITS'(1);
    assign rear_idx = rear_pos[IDX_BITS-1:0];

    // Result valid: set on report, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.report) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload from the updated queue
    always_ff @(posedge aclk) begin
        if (cmd.report) begin
            out_status_reg <= status_reg;
            out_found_reg  <= found_reg;
            out_count_reg  <= count_reg;
            out_empty_reg  <= (count_reg == '0);
            out_front_reg  <= (count_reg == '0) ? '0 : entry_reg[0];
            out_rear_reg   <= (count_reg == '0) ? '0 : entry_reg[rear_idx];
        end
    end

    assign stat.res_pending = out_valid_reg;
    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_found        = out_found_reg;
    assign out_count        = out_count_reg;
    assign out_empty        = out_empty_reg;
    assign out_front        = out_front_reg;
    assign out_rear         = out_rear_reg;

endmodule

@@ hdl/keyed_fifo_with_cancel.sv @@
// Keyed FIFO with cancel: the result is valid once the request has passed compare, apply
// and report, later while an earlier result still waits untaken in the output register.
// One request at a time: capture, compare all entries, shift/update,
// then load the result register; the controller steps through these in order.
// A new request is taken while the previous result waits in its output register.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
module keyed_fifo_with_cancel
    import kfc_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // key
    input  logic [((KEY_BITS + 7) / 8) * 8 - 1:0]         s_axis_tdata,
    // mode
    input  logic [1:0]                                    s_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // status, found, entry_count, is_empty, front_key, rear_key
    output logic [((4 + $clog2(DEPTH + 1) + 2 * KEY_BITS + 7) / 8) * 8 - 1:0]
                                                          m_axis_tdata
);

    `include "keyed_fifo_with_cancel_macros.svh"

    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int M_DATA_BITS = ((4 + CNT_BITS + 2 * KEY_BITS + 7) / 8) * 8;

    kfc_cmd_t            cmd;
    kfc_stat_t           stat;
    kfc_status_t         res_status;
    logic                res_found;
    logic [CNT_BITS-1:0] res_count;
    logic                res_empty;
    logic [KEY_BITS-1:0] res_front;
    logic [KEY_BITS-1:0] res_rear;

    kfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kfc_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (kfc_mode_t'(s_axis_tuser)),
        .in_key     (s_axis_tdata[KEY_BITS-1:0]),
        .m_ready    (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (res_status),
        .out_found  (res_found),
        .out_count  (res_count),
        .out_empty  (res_empty),
        .out_front  (res_front),
        .out_rear   (res_rear)
    );

    // Pack result fields, lowest first, zero padded to whole bytes
    assign m_axis_tdata = M_DATA_BITS'({res_rear, res_front, res_empty, res_count,
                                        res_found, res_status});

    // One request in flight at a time
    `KFC_ASSERT_NEXT(a_single_request, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while another is in flight")

    // Never overwrite a result that has not been taken
    `KFC_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.report, !m_axis_tvalid || m_axis_tready, "result register overwritten while pending")

    // A refused append only happens on a full queue
    `KFC_ASSERT_NOW(a_full_refusal, aclk, aresetn, m_axis_tvalid && res_status == STAT_FULL, res_count == CNT_BITS'(DEPTH) && !res_found, "append refused below full occupancy")

    // Occupancy never exceeds the depth
    `KFC_ASSERT_NOW(a_count_bound, aclk, aresetn, m_axis_tvalid, res_count <= CNT_BITS'(DEPTH) && res_empty == (res_count == '0), "reported occupancy out of range")

endmodule
